// ===== rtl/core/swrsp_pkg.sv =====
// shared constants, operation and status codes for the sorted-push stack
`timescale 1ns / 1ps
`default_nettype none

package swrsp_pkg;

	// stack geometry
	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// stream payload widths
	localparam int VALUE_W     = 32;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int OP_W        = 2;
	localparam int OUT_FIELD_W = DATA_W + STATUS_W + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef logic signed [WORD_WIDTH-1:0] word_t;

	// operation codes carried on the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_PUSH      = 2'd0,
		OP_POP       = 2'd1,
		OP_REVERSE   = 2'd2,
		OP_SORT_PUSH = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/swrsp_ram.sv =====
// simple dual-port ram: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module swrsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/stack_with_reverse_and_sorted_push_top.sv =====
// top level of the lifo stack with reverse and sorted push
`timescale 1ns / 1ps
`default_nettype none

// A 16-deep stack of signed 32-bit words driven by one operation per input
// transfer: push, pop, reverse, or push followed by an ascending sort (largest
// on top). Each operation returns exactly one result transfer carrying the
// popped word (zero otherwise), a status (ok, pop on empty, push on full) and
// the entry count afterward. The entries sit in a ram with one write and one
// registered read port, and a single signed comparator does all sorting. A
// sorted push that grows the stack to n entries (n >= 2) runs bubble passes
// from top to bottom until a pass makes no swap: one or two passes when the
// stack was already in order, at most n passes; onto an empty stack, none.
// The block takes no new operation until the current one has produced its
// result; one finished result may wait in the output register meanwhile.

module stack_with_reverse_and_sorted_push_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [swrsp_pkg::VALUE_W-1:0]       s_tdata,   // value[31:0]
	input  wire logic [swrsp_pkg::OP_W-1:0]          s_tuser,   // op[1:0]
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [swrsp_pkg::OUT_TDATA_W-1:0]   m_tdata    // data[31:0], status[33:32],
	                                                            // count[38:34], zero pad
);

	localparam int AW = swrsp_pkg::ADDR_W;
	localparam int CW = swrsp_pkg::CNT_W;
	localparam int WW = swrsp_pkg::WORD_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_RD,
		S_REV_HI,
		S_REV_W1,
		S_REV_W2,
		S_SRT_START,
		S_SRT_LOAD,
		S_SRT_RUN,
		S_SRT_LAST,
		S_RESP
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               fill_q;
	logic [AW-1:0]               lo_q;
	logic [AW-1:0]               hi_q;
	logic [AW-1:0]               idx_q;
	swrsp_pkg::word_t            tmp_q;
	swrsp_pkg::word_t            carry_q;
	logic                        swap_q;
	logic [swrsp_pkg::DATA_W-1:0] res_data_q;
	swrsp_pkg::status_t          res_status_q;
	logic                        m_valid_q;
	logic [swrsp_pkg::DATA_W-1:0] out_data_q;
	swrsp_pkg::status_t          out_status_q;
	logic [CW-1:0]               out_count_q;

	logic                        accept;
	swrsp_pkg::op_t              op;
	logic                        full;
	logic                        empty;
	logic [AW-1:0]               top_addr;
	logic [AW-1:0]               fill_addr;
	swrsp_pkg::word_t            in_word;
	swrsp_pkg::word_t            rd_word;
	logic [WW-1:0]               rd_data;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [WW-1:0]               ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic                        swap_now;
	logic                        rev_more;
	logic                        out_load;

	// entry storage
	swrsp_ram #(
		.WIDTH(WW),
		.DEPTH(swrsp_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// input decode and status flags
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign op        = swrsp_pkg::op_t'(s_tuser);
	assign full      = (fill_q == CW'(swrsp_pkg::DEPTH));
	assign empty     = (fill_q == '0);
	assign top_addr  = AW'(fill_q - CW'(1));
	assign fill_addr = fill_q[AW-1:0];
	assign in_word   = swrsp_pkg::word_t'(s_tdata[WW-1:0]);
	assign rd_word   = swrsp_pkg::word_t'(rd_data);

	// shared comparator: the word read lies below the carried word but is larger
	assign swap_now = (rd_word > carry_q);

	// another pair left to swap after the current one
	assign rev_more = ((AW + 1)'(lo_q) + (AW + 1)'(2)) < (AW + 1)'(hi_q);

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_addr;
		ram_wdata = in_word;
		ram_raddr = top_addr;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (op == swrsp_pkg::OP_PUSH || op == swrsp_pkg::OP_SORT_PUSH)
						&& !full) begin
					ram_we = 1'b1;
				end
				if (op == swrsp_pkg::OP_REVERSE) begin
					ram_raddr = '0;
				end
			end
			S_POP_RD: begin
				ram_raddr = top_addr;
			end
			S_REV_HI: begin
				ram_raddr = hi_q;
			end
			S_REV_W1: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = rd_data;
				ram_raddr = hi_q;
			end
			S_REV_W2: begin
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = tmp_q;
				ram_raddr = AW'(lo_q + AW'(1));
			end
			S_SRT_START: begin
				ram_raddr = top_addr;
			end
			S_SRT_LOAD: begin
				ram_raddr = AW'(top_addr - AW'(1));
			end
			S_SRT_RUN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q + AW'(1));
				ram_wdata = swap_now ? rd_data : carry_q;
				ram_raddr = AW'(idx_q - AW'(1));
			end
			S_SRT_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = carry_q;
				ram_raddr = top_addr;
			end
			S_RESP: begin
				ram_raddr = top_addr;
			end
			default: begin
				ram_raddr = top_addr;
			end
		endcase
	end

	assign out_load = (state_q == S_RESP) && (!m_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			swap_q       <= 1'b0;
			res_status_q <= swrsp_pkg::STAT_OK;
			res_data_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_data_q   <= '0;
						res_status_q <= swrsp_pkg::STAT_OK;
						unique case (op)
							swrsp_pkg::OP_PUSH: begin
								if (full) begin
									res_status_q <= swrsp_pkg::STAT_FULL;
								end else begin
									fill_q <= CW'(fill_q + CW'(1));
								end
								state_q <= S_RESP;
							end
							swrsp_pkg::OP_SORT_PUSH: begin
								if (full) begin
									res_status_q <= swrsp_pkg::STAT_FULL;
									state_q      <= S_RESP;
								end else begin
									fill_q  <= CW'(fill_q + CW'(1));
									swap_q  <= 1'b0;
									state_q <= empty ? S_RESP : S_SRT_START;
								end
							end
							swrsp_pkg::OP_POP: begin
								if (empty) begin
									res_status_q <= swrsp_pkg::STAT_EMPTY;
									state_q      <= S_RESP;
								end else begin
									fill_q  <= CW'(fill_q - CW'(1));
									state_q <= S_POP_RD;
								end
							end
							swrsp_pkg::OP_REVERSE: begin
								if (fill_q < CW'(2)) begin
									state_q <= S_RESP;
								end else begin
									lo_q    <= '0;
									hi_q    <= top_addr;
									state_q <= S_REV_HI;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_POP_RD: begin
					res_data_q <= swrsp_pkg::DATA_W'(rd_word);
					state_q    <= S_RESP;
				end
				// reverse: read low, read high, write both
				S_REV_HI: begin
					tmp_q   <= rd_word;
					state_q <= S_REV_W1;
				end
				S_REV_W1: begin
					state_q <= S_REV_W2;
				end
				S_REV_W2: begin
					lo_q    <= AW'(lo_q + AW'(1));
					hi_q    <= AW'(hi_q - AW'(1));
					state_q <= rev_more ? S_REV_HI : S_RESP;
				end
				// sort: bubble passes from the top, carrying the smaller word down
				S_SRT_START: begin
					state_q <= S_SRT_LOAD;
				end
				S_SRT_LOAD: begin
					carry_q <= rd_word;
					idx_q   <= AW'(top_addr - AW'(1));
					state_q <= S_SRT_RUN;
				end
				S_SRT_RUN: begin
					if (swap_now) begin
						swap_q <= 1'b1;
					end else begin
						carry_q <= rd_word;
					end
					if (idx_q == '0) begin
						state_q <= S_SRT_LAST;
					end else begin
						idx_q <= AW'(idx_q - AW'(1));
					end
				end
				S_SRT_LAST: begin
					swap_q  <= 1'b0;
					state_q <= swap_q ? S_SRT_LOAD : S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_count_q  <= fill_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = swrsp_pkg::OUT_TDATA_W'({out_count_q, out_status_q, out_data_q});

endmodule

`default_nettype wire

// ===== tb/sv/stack_with_reverse_and_sorted_push_top_test.sv =====
// self-checking testbench for the lifo stack with reverse and sorted push
`timescale 1ns / 1ps

module stack_with_reverse_and_sorted_push_top_test;
	import swrsp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int TAIL_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 750;

	typedef struct packed {
		word_t                data;
		status_t              status;
		logic [CNT_W-1:0]     count;
	} stack_result_t;

	// stack scoreboard: mirrors the stack contents and checks every result transfer
	class stack_scoreboard;
		word_t            shadow [DEPTH];
		int               fill;
		stack_result_t    awaited [$];
		int               errors;
		int               checked;
		int               op_seen [4];
		int               empty_pops;
		int               full_pushes;

		function new();
			fill = 0;
			errors = 0;
			checked = 0;
			empty_pops = 0;
			full_pushes = 0;
			foreach (op_seen[k]) op_seen[k] = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// stable ascending sort of the filled entries, largest ends on top
		function void sort_stack();
			int    i;
			int    j;
			word_t cur;
			for (i = 1; i < fill; i++) begin
				cur = shadow[i];
				j = i;
				while (j > 0 && shadow[j-1] > cur) begin
					shadow[j] = shadow[j-1];
					j--;
				end
				shadow[j] = cur;
			end
		endfunction

		// note an accepted operation and queue the result it must produce
		function void note_input(op_t op, word_t value);
			stack_result_t r;
			word_t         t;
			int            lo;
			int            hi;
			r.data = '0;
			r.status = STAT_OK;
			op_seen[op]++;
			case (op)
				OP_PUSH, OP_SORT_PUSH: begin
					if (fill >= DEPTH) begin
						r.status = STAT_FULL;
						full_pushes++;
					end else begin
						shadow[fill] = value;
						fill++;
						if (op == OP_SORT_PUSH) sort_stack();
					end
				end
				OP_POP: begin
					if (fill == 0) begin
						r.status = STAT_EMPTY;
						empty_pops++;
					end else begin
						fill--;
						r.data = shadow[fill];
					end
				end
				default: begin
					lo = 0;
					hi = fill - 1;
					while (lo < hi) begin
						t = shadow[lo];
						shadow[lo] = shadow[hi];
						shadow[hi] = t;
						lo++;
						hi--;
					end
				end
			endcase
			r.count = fill[CNT_W-1:0];
			awaited.push_back(r);
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(logic [OUT_TDATA_W-1:0] payload);
			stack_result_t exp_r;
			word_t         got_data;
			logic [1:0]    got_status;
			logic [4:0]    got_count;
			got_data = payload[31:0];
			got_status = payload[33:32];
			got_count = payload[38:34];
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual data %0d status %0d count %0d",
					$time, got_data, got_status, got_count);
				errors++;
				return;
			end
			exp_r = awaited.pop_front();
			checked++;
			if (got_data !== exp_r.data) begin
				$display("%0t: data mismatch, expected %0d, actual %0d",
					$time, exp_r.data, got_data);
				errors++;
			end
			if (got_status !== exp_r.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, exp_r.status, got_status);
				errors++;
			end
			if (got_count !== exp_r.count) begin
				$display("%0t: count mismatch, expected %0d, actual %0d",
					$time, exp_r.count, got_count);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [VALUE_W-1:0]      s_tdata = '0;
	logic [OP_W-1:0]         s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;

	stack_scoreboard sb = new();
	int              cycles = 0;
	int              burst_left = 0;

	stack_with_reverse_and_sorted_push_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited", cycles, sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: free-running, then with regular stalls, then random, then long stalls
	always @(posedge clk) begin
		case (cycles[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= (cycles[1:0] != 2'd0);
			2'd2: m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= (cycles[5:0] >= 6'd40);
		endcase
	end

	// monitors for both streams
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_input(op_t'(s_tuser), word_t'(s_tdata));
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// one operation transfer, then maybe a gap before the next burst
	task automatic issue(input op_t op, input word_t value);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off the sender until every queued result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// push value mix: extremes, near-duplicates and full-width random words
	function automatic word_t pick_value();
		case ($urandom_range(0, 7))
			0: return word_t'(32'h8000_0000);
			1: return word_t'(32'h7fff_ffff);
			2: return word_t'($urandom_range(0, 8)) - 4;
			3: return ($urandom_range(0, 1) != 0) ? word_t'(-1) : word_t'(0);
			default: return word_t'($urandom);
		endcase
	endfunction

	// op mix for fill-heavy, drain-heavy, uniform and sort-heavy phases
	function automatic op_t pick_op(input int mode);
		int r;
		r = $urandom_range(0, 9);
		case (mode)
			0: return (r < 4) ? OP_PUSH : (r < 7) ? OP_SORT_PUSH : (r == 8) ? OP_REVERSE : OP_POP;
			1: return (r < 6 || r == 9) ? OP_POP : (r == 6) ? OP_PUSH :
				(r == 7) ? OP_SORT_PUSH : OP_REVERSE;
			2: return op_t'(r % 4);
			default: return (r < 5) ? OP_SORT_PUSH : (r < 8) ? OP_POP :
				(r == 8) ? OP_REVERSE : OP_PUSH;
		endcase
	endfunction

	initial begin
		int mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-stack cases, single-entry reverse, extremes, equal sorted values
		issue(OP_POP, word_t'($urandom));
		issue(OP_REVERSE, word_t'($urandom));
		issue(OP_PUSH, word_t'(32'h7fff_ffff));
		issue(OP_REVERSE, '0);
		issue(OP_SORT_PUSH, word_t'(32'h8000_0000));
		issue(OP_SORT_PUSH, word_t'(-1));
		issue(OP_SORT_PUSH, word_t'(-1));
		issue(OP_PUSH, '0);
		issue(OP_REVERSE, '0);
		issue(OP_POP, '0);
		// fill to the top, then push and sorted push on a full stack
		for (int k = 0; k < 12; k++)
			issue((k % 2 == 0) ? OP_SORT_PUSH : OP_PUSH, pick_value());
		issue(OP_PUSH, word_t'(32'h1234_5678));
		issue(OP_SORT_PUSH, word_t'(32'h8765_4321));
		issue(OP_REVERSE, '0);
		drain_results();

		// random phases
		mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) mode = $urandom_range(0, 3);
			if (n % 150 == 149) drain_results();
			issue(pick_op(mode), pick_value());
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ops accepted: push %0d, pop %0d, reverse %0d, sorted push %0d; results checked %0d",
			sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_REVERSE],
			sb.op_seen[OP_SORT_PUSH], sb.checked);
		$display("pops on an empty stack %0d, pushes on a full stack %0d, errors %0d",
			sb.empty_pops, sb.full_pushes, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/swrsp_pkg.sv
rtl/core/swrsp_ram.sv
rtl/core/stack_with_reverse_and_sorted_push_top.sv
tb/sv/stack_with_reverse_and_sorted_push_top_test.sv
